// File: rtl/core/mphe_pkg.sv
// Shared types and constants for the MQTT PUBLISH header encoder.
`timescale 1ns / 1ps

package mphe_pkg;

    localparam int unsigned MAX_RESULTS = 7;
    localparam int unsigned CNT_W       = 3;

    localparam logic [7:0]  FIRST_BYTE    = 8'h30;
    localparam logic [7:0]  CONT_BIT      = 8'h80;
    localparam logic [28:0] MAX_REMAINING = 29'd268435455;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TOPIC = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_NO_ROOM = 2'd2;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            cnt;
        logic [1:0]                  status;
    } t_burst;

endpackage

// File: rtl/core/mphe_decode.sv
// Per-item encoder: builds the full result burst and the next header flag.
`timescale 1ns / 1ps

module mphe_decode (
    input  logic                  i_req_type,
    input  logic [15:0]           i_topic_len,
    input  logic [27:0]           i_payload_len,
    input  logic                  i_retain,
    input  logic [16:0]           i_out_capacity,
    input  logic [7:0]            i_topic_byte,
    input  logic                  i_topic_last,
    input  logic                  i_hdr_acc,
    output mphe_pkg::t_burst      o_burst,
    output logic                  o_hdr_acc
);

    logic [28:0]      rem;
    logic [2:0]       vlen;
    logic [17:0]      need;
    logic             bad_len;
    logic             no_room;
    logic [3:0][6:0]  grp;

    assign rem     = 29'd2 + 29'(i_topic_len) + 29'(i_payload_len);
    assign bad_len = (i_topic_len == 16'd0) || (rem > mphe_pkg::MAX_REMAINING);
    assign grp[0]  = rem[6:0];
    assign grp[1]  = rem[13:7];
    assign grp[2]  = rem[20:14];
    assign grp[3]  = rem[27:21];

    always_comb begin
        if (rem < 29'd128) begin
            vlen = 3'd1;
        end else if (rem < 29'd16384) begin
            vlen = 3'd2;
        end else if (rem < 29'd2097152) begin
            vlen = 3'd3;
        end else begin
            vlen = 3'd4;
        end
    end

    assign need    = 18'(vlen) + 18'd3 + 18'(i_topic_len);
    assign no_room = need > 18'(i_out_capacity);

    always_comb begin
        o_burst   = '0;
        o_hdr_acc = i_hdr_acc;
        if (i_req_type == mphe_pkg::REQ_START) begin
            if (bad_len) begin
                o_burst.cnt    = 3'd1;
                o_burst.status = mphe_pkg::ST_BAD_LEN;
                o_hdr_acc      = 1'b0;
            end else if (no_room) begin
                o_burst.cnt    = 3'd1;
                o_burst.status = mphe_pkg::ST_NO_ROOM;
                o_hdr_acc      = 1'b0;
            end else begin
                o_burst.bytes[0] = mphe_pkg::FIRST_BYTE | {7'd0, i_retain};
                for (int j = 0; j < 4; j++) begin
                    if (3'(j) < vlen) begin
                        o_burst.bytes[j+1] = {1'b0, grp[j]} |
                            ((3'(j + 1) < vlen) ? mphe_pkg::CONT_BIT : 8'd0);
                    end
                end
                o_burst.bytes[vlen + 3'd1] = i_topic_len[15:8];
                o_burst.bytes[vlen + 3'd2] = i_topic_len[7:0];
                o_burst.cnt    = vlen + 3'd3;
                o_burst.status = mphe_pkg::ST_OK;
                o_hdr_acc      = 1'b1;
            end
        end else if (i_hdr_acc) begin
            o_burst.bytes[0] = i_topic_byte;
            o_burst.cnt      = 3'd1;
            o_burst.status   = mphe_pkg::ST_OK;
            if (i_topic_last) begin
                o_hdr_acc = 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/mphe_burst.sv
// Output register: holds one burst and hands it out a byte per transfer.
`timescale 1ns / 1ps

module mphe_burst (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  mphe_pkg::t_burst      i_burst,
    output logic                  o_free,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_of_run,
    output logic [1:0]            o_status
);

    logic                  r_valid;
    logic                  n_valid;
    mphe_pkg::t_burst      r_burst;
    logic [mphe_pkg::CNT_W-1:0] r_idx;
    logic [mphe_pkg::CNT_W-1:0] n_idx;
    logic                  last;
    logic                  take;

    assign last   = (r_idx == (r_burst.cnt - 3'd1));
    assign take   = r_valid && !i_out_stall;
    assign o_free = !r_valid || (take && last);

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = '0;
        end else if (take) begin
            if (last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_burst.bytes[r_idx];
    assign o_last_of_run = last;
    assign o_status      = r_burst.status;

endmodule

// File: rtl/core/mqtt_publish_header_encoder_top.sv
// MQTT PUBLISH header encoder: input register, encoder and output burst register.
// The first result passes the input register and then the output burst register.
// Throughput: one topic byte per cycle while the output is not stalled; a start item
// yields 4 to 7 header bytes, or 1 status byte on an error, from the output burst register.
// Reset (synchronous, active low) empties both registers and clears the header flag.
`timescale 1ns / 1ps

module mqtt_publish_header_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_topic_len,
    input  logic [27:0] i_payload_len,
    input  logic        i_retain,
    input  logic [16:0] i_out_capacity,
    input  logic [7:0]  i_topic_byte,
    input  logic        i_topic_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic [1:0]  o_status
);

    logic        r_in_valid;
    logic        n_in_valid;
    logic        r_req_type;
    logic [15:0] r_topic_len;
    logic [27:0] r_payload_len;
    logic        r_retain;
    logic [16:0] r_out_capacity;
    logic [7:0]  r_topic_byte;
    logic        r_topic_last;
    logic        r_hdr_acc;
    logic        n_hdr_acc;

    mphe_pkg::t_burst burst;
    logic        free;
    logic        advance;
    logic        load;
    logic        in_take;

    mphe_decode u_decode (
        .i_req_type     (r_req_type),
        .i_topic_len    (r_topic_len),
        .i_payload_len  (r_payload_len),
        .i_retain       (r_retain),
        .i_out_capacity (r_out_capacity),
        .i_topic_byte   (r_topic_byte),
        .i_topic_last   (r_topic_last),
        .i_hdr_acc      (r_hdr_acc),
        .o_burst        (burst),
        .o_hdr_acc      (n_hdr_acc)
    );

    assign advance    = r_in_valid && ((burst.cnt == 3'd0) || free);
    assign load       = r_in_valid && free && (burst.cnt != 3'd0);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_hdr_acc  <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (advance) begin
                r_hdr_acc <= n_hdr_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req_type     <= i_req_type;
            r_topic_len    <= i_topic_len;
            r_payload_len  <= i_payload_len;
            r_retain       <= i_retain;
            r_out_capacity <= i_out_capacity;
            r_topic_byte   <= i_topic_byte;
            r_topic_last   <= i_topic_last;
        end
    end

    mphe_burst u_burst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_burst       (burst),
        .o_free        (free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_status      (o_status)
    );

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the MQTT PUBLISH header encoder: directed and random transfers, scoreboard check.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic        req;
        logic [15:0] tlen;
        logic [27:0] plen;
        logic        ret;
        logic [16:0] cap;
        logic [7:0]  tbyte;
        logic        tlast;
    } t_pub_req;

    typedef struct packed {
        logic [7:0] obyte;
        logic       olast;
        logic [1:0] ostat;
    } t_pkt_byte;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic        i_req_type     = mphe_pkg::REQ_START;
    logic [15:0] i_topic_len    = '0;
    logic [27:0] i_payload_len  = '0;
    logic        i_retain       = 1'b0;
    logic [16:0] i_out_capacity = '0;
    logic [7:0]  i_topic_byte   = '0;
    logic        i_topic_last   = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;
    logic [1:0]  o_status;

    t_pkt_byte   expected_bytes[$];
    t_pkt_byte   head_byte;
    bit          header_open      = 1'b0;
    bit          idle_on          = 1'b0;
    int unsigned productive_items = 0;
    int unsigned mismatches       = 0;
    int unsigned cycles           = 0;
    int unsigned stall_hold       = 0;

    mqtt_publish_header_encoder_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_topic_len    (i_topic_len),
        .i_payload_len  (i_payload_len),
        .i_retain       (i_retain),
        .i_out_capacity (i_out_capacity),
        .i_topic_byte   (i_topic_byte),
        .i_topic_last   (i_topic_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL mqtt_publish_header_encoder_top");
            $finish;
        end
    end

    function automatic void push_byte(input logic [7:0] b, input logic l, input logic [1:0] s);
        expected_bytes.push_back('{obyte: b, olast: l, ostat: s});
    endfunction

    // Expected packet bytes for one accepted transfer
    function automatic void encode_publish_header(input t_pub_req r);
        logic [28:0] rem;
        logic [7:0]  grp;
        int unsigned vlen;
        int unsigned i;
        logic [1:0]  st;
        if (r.req == mphe_pkg::REQ_START) begin
            rem  = {13'd0, r.tlen} + {1'b0, r.plen} + 29'd2;
            vlen = (rem < 29'd128) ? 1 : (rem < 29'd16384) ? 2 : (rem < 29'd2097152) ? 3 : 4;
            st   = mphe_pkg::ST_OK;
            if (r.tlen == 16'd0 || rem > mphe_pkg::MAX_REMAINING)
                st = mphe_pkg::ST_BAD_LEN;
            else if (vlen + 3 + int'(r.tlen) > int'(r.cap))
                st = mphe_pkg::ST_NO_ROOM;
            if (st != mphe_pkg::ST_OK) begin
                push_byte(8'h00, 1'b1, st);
                header_open = 1'b0;
            end else begin
                push_byte(mphe_pkg::FIRST_BYTE | {7'd0, r.ret}, 1'b0, mphe_pkg::ST_OK);
                for (i = 0; i < vlen; i++) begin
                    grp = {1'b0, rem[6:0]};
                    rem = rem >> 7;
                    if (i + 1 < vlen)
                        grp = grp | mphe_pkg::CONT_BIT;
                    push_byte(grp, 1'b0, mphe_pkg::ST_OK);
                end
                push_byte(r.tlen[15:8], 1'b0, mphe_pkg::ST_OK);
                push_byte(r.tlen[7:0], 1'b1, mphe_pkg::ST_OK);
                header_open = 1'b1;
            end
            productive_items++;
        end else if (header_open) begin
            push_byte(r.tbyte, 1'b1, mphe_pkg::ST_OK);
            if (r.tlast)
                header_open = 1'b0;
            productive_items++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                encode_publish_header('{req: i_req_type, tlen: i_topic_len,
                    plen: i_payload_len, ret: i_retain, cap: i_out_capacity,
                    tbyte: i_topic_byte, tlast: i_topic_last});
            if (o_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: byte %h last %b status %0d",
                                 o_out_byte, o_last_of_run, o_status);
                end else begin
                    head_byte = expected_bytes.pop_front();
                    if (o_out_byte !== head_byte.obyte || o_last_of_run !== head_byte.olast ||
                        o_status !== head_byte.ostat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: byte %h/%h last %b/%b status %0d/%0d (got/exp)",
                                     o_out_byte, head_byte.obyte, o_last_of_run,
                                     head_byte.olast, o_status, head_byte.ostat);
                    end
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (!idle_on)
            return 0;
        if (r == 0)
            return $urandom_range(8, 30);
        if (r <= 7)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_hold  <= pick_gap();
        end else begin
            i_out_stall <= 1'b0;
            stall_hold  <= $urandom_range(0, 4);
        end
    end

    function automatic t_pub_req make_start(input logic [15:0] tl, input logic [27:0] pl,
                                            input logic rt, input logic [16:0] cp);
        t_pub_req r;
        r.req   = mphe_pkg::REQ_START;
        r.tlen  = tl;
        r.plen  = pl;
        r.ret   = rt;
        r.cap   = cp;
        r.tbyte = 8'($urandom_range(0, 255));
        r.tlast = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_pub_req make_topic(input logic [7:0] b, input logic l);
        t_pub_req r;
        r.req   = mphe_pkg::REQ_TOPIC;
        r.tlen  = 16'($urandom_range(0, 65535));
        r.plen  = 28'($urandom);
        r.ret   = 1'($urandom_range(0, 1));
        r.cap   = 17'($urandom_range(0, 65543));
        r.tbyte = b;
        r.tlast = l;
        return r;
    endfunction

    task automatic send_item(input t_pub_req r);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_type     <= r.req;
        i_topic_len    <= r.tlen;
        i_payload_len  <= r.plen;
        i_retain       <= r.ret;
        i_out_capacity <= r.cap;
        i_topic_byte   <= r.tbyte;
        i_topic_last   <= r.tlast;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_all_received();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_topic_len();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return 16'($urandom_range(1, 16));
        if (r < 18)
            return 16'($urandom_range(17, 300));
        if (r == 18)
            return 16'hffff;
        return 16'($urandom_range(1, 65535));
    endfunction

    // Payload lengths biased towards the varint group boundaries and the maximum
    function automatic logic [27:0] rand_payload_len(input logic [15:0] tl);
        int r;
        int edge_rem;
        int pl;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 28'($urandom_range(0, 300));
        if (r < 7) begin
            case ($urandom_range(0, 3))
                0: begin edge_rem = 127; end
                1: begin edge_rem = 16383; end
                2: begin edge_rem = 2097151; end
                default: begin edge_rem = 268435455; end
            endcase
            pl = edge_rem - 2 - int'(tl) + int'($urandom_range(0, 2)) - 1;
            return (pl < 0) ? 28'd0 : pl[27:0];
        end
        if (r < 9)
            return 28'($urandom);
        return 28'(28'hfffffff - $urandom_range(0, 70000));
    endfunction

    task automatic test_directed_cases();
        send_item(make_start(16'd0, 28'd10, 1'b0, 17'd65543));
        send_item(make_start(16'd1, 28'd0, 1'b0, 17'd65543));
        send_item(make_topic(8'h00, 1'b0));
        send_item(make_topic(8'hff, 1'b1));
        send_item(make_topic(8'ha5, 1'b1));
        send_item(make_start(16'd1, 28'd124, 1'b1, 17'd6));
        send_item(make_start(16'd1, 28'd125, 1'b0, 17'd5));
        send_item(make_start(16'd1, 28'd125, 1'b0, 17'd6));
        send_item(make_start(16'd2, 28'd16379, 1'b1, 17'd65543));
        send_item(make_start(16'd2, 28'd16380, 1'b0, 17'd65543));
        send_item(make_start(16'd1, 28'd2097148, 1'b0, 17'd65543));
        send_item(make_start(16'd1, 28'd2097149, 1'b1, 17'd65543));
        send_item(make_start(16'd1, 28'd268435452, 1'b1, 17'd8));
        send_item(make_start(16'd1, 28'd268435453, 1'b0, 17'd65543));
        send_item(make_start(16'hffff, 28'd268369918, 1'b1, 17'd65542));
        send_item(make_start(16'hffff, 28'd268369918, 1'b1, 17'd65541));
        send_item(make_start(16'hffff, 28'd268369919, 1'b0, 17'd65543));
        send_item(make_start(16'd1, 28'hfffffff, 1'b1, 17'd65543));
        send_item(make_start(16'd3, 28'd0, 1'b0, 17'd0));
        send_item(make_start(16'd5, 28'd40, 1'b0, 17'd65543));
        send_item(make_start(16'd4, 28'd0, 1'b1, 17'd65543));
        send_item(make_topic(8'h5a, 1'b0));
        send_item(make_start(16'd0, 28'd0, 1'b1, 17'd65543));
        send_item(make_topic(8'h3c, 1'b1));
    endtask

    task automatic test_well_formed_sequences(input int unsigned target);
        int unsigned goal;
        int unsigned nbytes;
        int unsigned k;
        logic [15:0] tl;
        logic [16:0] cp;
        bit          broken;
        goal = productive_items + target;
        while (productive_items < goal) begin
            tl = rand_topic_len();
            cp = {1'b0, tl} + 17'($urandom_range(4, 8));
            send_item(make_start(tl, rand_payload_len(tl), 1'($urandom_range(0, 1)), cp));
            nbytes = $urandom_range(1, 8);
            broken = ($urandom_range(0, 7) == 0);
            for (k = 0; k < nbytes; k++)
                send_item(make_topic(8'($urandom_range(0, 255)),
                                     (k + 1 == nbytes) && !broken));
            if ($urandom_range(0, 24) == 0)
                wait_all_received();
        end
    endtask

    task automatic test_noise_and_broken(input int unsigned target);
        int unsigned goal;
        logic [15:0] tl;
        goal = productive_items + target;
        while (productive_items < goal) begin
            tl = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 0)
                send_item(make_start(tl, 28'($urandom), 1'($urandom_range(0, 1)),
                                     17'($urandom_range(0, 65543))));
            else
                send_item(make_topic(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic test_back_to_back(input int unsigned target);
        idle_on = 1'b0;
        test_well_formed_sequences(target);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        wait_all_received();
        idle_on = 1'b1;
        test_well_formed_sequences(180);
        wait_all_received();
        test_noise_and_broken(70);
        test_back_to_back(40);
        wait_all_received();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("PASS mqtt_publish_header_encoder_top");
        else
            $display("FAIL mqtt_publish_header_encoder_top");
        $finish;
    end

endmodule
